>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FRP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define FRP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/frp_pkg.sv
// Types, constants and constant functions of the fringe rotation phasor.
package frp_pkg;

  localparam int PHASE_BITS    = 32;
  localparam int CORDIC_STAGES = 30;
  localparam int W_ACC         = 89;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [63:0] Q60_ONE        = 64'h1000_0000_0000_0000;
  localparam logic [63:0] TWO_PI_Q60     = 64'h6487ED5110B4611A;
  localparam logic [63:0] PI_QUARTER_Q60 = 64'h0C90FDAA22168C23;
  localparam logic [63:0] GAIN_Q60       = 64'd700114967507363238;
  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  localparam logic [2:0] REG_SIDEBAND   = 3'd0;
  localparam logic [2:0] REG_BIN_COUNT  = 3'd1;
  localparam logic [2:0] REG_PEAK_BIN   = 3'd2;
  localparam logic [2:0] REG_PEAK_DELAY = 3'd3;
  localparam logic [2:0] REG_RECIP      = 3'd4;
  localparam logic [2:0] REG_CLOSURE    = 3'd5;
  localparam logic [2:0] REG_REF_FREQ   = 3'd6;

  localparam logic [1:0] SB_PLUS  = 2'b01;
  localparam logic [1:0] SB_MINUS = 2'b11;
  localparam logic [1:0] SB_TWO   = 2'b10;

  typedef struct packed {
    logic signed [31:0] time_offset;
    logic        [31:0] channel_freq;
    logic signed [47:0] dly_rate;
    logic signed [47:0] multiband_delay;
  } req_t;

  typedef struct packed {
    logic signed [31:0] phasor_real;
    logic signed [31:0] phasor_imag;
  } rsp_t;

  typedef struct packed {
    logic signed [1:0]  sideband_sign;
    logic        [13:0] sbd_bin_count;
    logic        [13:0] sbd_peak_bin;
    logic signed [47:0] sbd_peak_delay;
    logic        [31:0] sbd_spacing_recip;
    logic               closure_optimise;
    logic        [31:0] reference_freq;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            quad;
    logic                  neg;
    logic [PHASE_BITS-1:0] mag;
  } qent_t;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Truncated arctangent series of 2^-i in Q60.
  function automatic logic [63:0] atan_pow2(input int i);
    logic [63:0] sum;
    int sh;
    sum = '0;
    if (i == 0) return PI_QUARTER_Q60;
    for (int k = 0; k < 64; k++) begin
      sh = i * (2 * k + 1);
      if (sh <= 60) begin
        if (k % 2 == 1) sum = sum - udiv64(Q60_ONE >> sh, 64'(2 * k + 1));
        else sum = sum + udiv64(Q60_ONE >> sh, 64'(2 * k + 1));
      end
    end
    return sum;
  endfunction

endpackage

>>> rtl/frp_regs.sv
// Configuration register file behind the APB-style port.
module frp_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output frp_pkg::cfg_t      cfg
);
  import frp_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[5:3];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{sbd_spacing_recip: 32'd65536, default: '0};
    end else if (wr) begin
      case (idx)
        REG_SIDEBAND:   cfg.sideband_sign     <= pwdata[1:0];
        REG_BIN_COUNT:  cfg.sbd_bin_count     <= pwdata[13:0];
        REG_PEAK_BIN:   cfg.sbd_peak_bin      <= pwdata[13:0];
        REG_PEAK_DELAY: cfg.sbd_peak_delay    <= pwdata[47:0];
        REG_RECIP:      cfg.sbd_spacing_recip <= pwdata[31:0];
        REG_CLOSURE:    cfg.closure_optimise  <= pwdata[0];
        REG_REF_FREQ:   cfg.reference_freq    <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SIDEBAND:   prdata = {{62{cfg.sideband_sign[1]}}, cfg.sideband_sign};
      REG_BIN_COUNT:  prdata = {50'd0, cfg.sbd_bin_count};
      REG_PEAK_BIN:   prdata = {50'd0, cfg.sbd_peak_bin};
      REG_PEAK_DELAY: prdata = {{16{cfg.sbd_peak_delay[47]}}, cfg.sbd_peak_delay};
      REG_RECIP:      prdata = {32'd0, cfg.sbd_spacing_recip};
      REG_CLOSURE:    prdata = {63'd0, cfg.closure_optimise};
      REG_REF_FREQ:   prdata = {32'd0, cfg.reference_freq};
      default:        prdata = '0;
    endcase
  end
endmodule

>>> rtl/frp_front.sv
// Front pipeline: phase accumulation and quadrant split.
module frp_front (
  input  logic             clk,
  input  logic             rst,
  input  frp_pkg::cfg_t    cfg,
  input  logic             req_valid,
  output logic             req_stall,
  input  frp_pkg::req_t    req_data,
  input  logic             q_full,
  output logic             q_push,
  output frp_pkg::qent_t   q_data
);
  import frp_pkg::*;

  localparam int PB = PHASE_BITS;

  logic [3:0] vld;
  logic       adv;

  // stage 1
  logic signed [63:0] ft1;
  logic signed [47:0] rate1;
  logic [44:0]        t2a1;
  logic [20:0]        t2b1;
  logic [50:0]        t3a1;
  logic [26:0]        t3b1;
  // stage 2
  logic [55:0]        pll2;
  logic signed [56:0] plh2;
  logic signed [56:0] phl2;
  logic signed [55:0] phh2;
  logic [44:0]        t2_2;
  logic [50:0]        t3_2;
  // stage 3
  logic [W_ACC-1:0]   t1_3;
  logic [44:0]        t2_3;
  logic [50:0]        t3s_3;
  // stage 4
  logic [PB-1:0]      p4;

  logic signed [32:0] dfreq;
  logic [47:0]        dly;
  logic [50:0]        t3s;
  logic [2:0]         t4;
  logic [2:0]         bdiff;
  logic [W_ACC-1:0]   t1_sum;
  logic [W_ACC-1:0]   acc;
  logic [PB-1:0]      pr;
  logic [1:0]         quad;
  logic [PB-1:0]      res;

  assign adv       = !vld[3] || !q_full;
  assign req_stall = !adv;
  assign q_push    = vld[3] && adv;

  assign dfreq = $signed({1'b0, req_data.channel_freq}) - $signed({1'b0, cfg.reference_freq});
  assign dly   = cfg.closure_optimise ? req_data.multiband_delay : cfg.sbd_peak_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ft1   <= 64'($signed({1'b0, req_data.channel_freq}) * req_data.time_offset);
      rate1 <= req_data.dly_rate;
      t2a1  <= 45'(dfreq * $signed({1'b0, req_data.multiband_delay[23:0]}));
      t2b1  <= 21'(dfreq * req_data.multiband_delay[47:24]);
      t3a1  <= 51'(dly[23:0] * cfg.sbd_spacing_recip);
      t3b1  <= 27'($signed(dly[47:24]) * $signed({1'b0, cfg.sbd_spacing_recip}));

      pll2 <= ft1[31:0] * rate1[23:0];
      plh2 <= $signed({1'b0, ft1[31:0]}) * $signed(rate1[47:24]);
      phl2 <= $signed(ft1[63:32]) * $signed({1'b0, rate1[23:0]});
      phh2 <= $signed(ft1[63:32]) * $signed(rate1[47:24]);
      t2_2 <= t2a1 + {t2b1, 24'd0};
      t3_2 <= t3a1 + {t3b1, 24'd0};

      t1_3  <= t1_sum;
      t2_3  <= t2_2;
      t3s_3 <= t3s;

      p4 <= acc[W_ACC-1 -: PB];
    end
  end

  assign t1_sum = {{(W_ACC-56){1'b0}}, pll2}
                + ({{(W_ACC-57){plh2[56]}}, plh2} << 24)
                + ({{(W_ACC-57){phl2[56]}}, phl2} << 32)
                + ({{(W_ACC-56){phh2[55]}}, phh2} << 56);

  assign bdiff = cfg.sbd_bin_count[2:0] - cfg.sbd_peak_bin[2:0];

  // scale by the sideband code; pattern 10 counts as minus two
  always_comb begin
    case (cfg.sideband_sign)
      SB_PLUS:  begin t3s = t3_2;              t4 = bdiff;              end
      SB_MINUS: begin t3s = -t3_2;             t4 = -bdiff;             end
      SB_TWO:   begin t3s = -{t3_2[49:0], 1'b0}; t4 = -{bdiff[1:0], 1'b0}; end
      default:  begin t3s = '0;                t4 = '0;                 end
    endcase
  end

  assign acc = t1_3 + {t2_3, 44'd0} + {t3s_3, 38'd0} + {t4, 86'd0};

  // split off the nearest quadrant, keep the signed residual
  assign pr   = p4 + (PB'(1) << (PB - 3));
  assign quad = pr[PB-1 -: 2];
  assign res  = p4 - {quad, {(PB-2){1'b0}}};

  assign q_data.quad = quad;
  assign q_data.neg  = res[PB-1];
  assign q_data.mag  = res[PB-1] ? -res : res;
endmodule

>>> rtl/frp_queue.sv
// Short queue between front and back pipelines.
module frp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  frp_pkg::qent_t wdata,
  input  logic           pop,
  output frp_pkg::qent_t rdata,
  output logic           full,
  output logic           empty
);
  import frp_pkg::*;

  qent_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end
endmodule

>>> rtl/frp_back.sv
// Back pipeline: angle scaling, CORDIC rotation and quadrant mapping.
module frp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  output logic           q_pop,
  input  frp_pkg::qent_t q_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output frp_pkg::rsp_t  rsp_data
);
  import frp_pkg::*;

  localparam int PB = PHASE_BITS;
  localparam int N  = CORDIC_STAGES;
  localparam int L  = N + 3;

  logic [L-1:0] vld;
  logic         adv;

  logic [PB+31:0] mhi;
  logic [PB+31:0] mlo;
  logic [1:0]     quad0;
  logic           neg0;

  logic signed [63:0] xs [N+1];
  logic signed [63:0] ys [N+1];
  logic signed [63:0] zs [N+1];
  logic [1:0]         qs [N+1];

  logic [PB+63:0]     full;
  logic [63:0]        ang;
  logic signed [31:0] c;
  logic signed [31:0] s;
  logic signed [31:0] re;
  logic signed [31:0] im;

  function automatic logic signed [31:0] to_q30(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd536870912) >>> 30;
    if (r > 64'(Q30_ONE)) return Q30_ONE;
    if (r < -64'(Q30_ONE)) return -Q30_ONE;
    return 32'(r);
  endfunction

  assign adv       = !vld[L-1] || !rsp_stall;
  assign q_pop     = !q_empty && adv;
  assign rsp_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], q_pop};
    end
  end

  assign full = {mhi, 32'd0} + {32'd0, mlo};
  assign ang  = full[PB+63:PB];

  always_ff @(posedge clk) begin
    if (adv) begin
      mhi   <= q_data.mag * TWO_PI_Q60[63:32];
      mlo   <= q_data.mag * TWO_PI_Q60[31:0];
      quad0 <= q_data.quad;
      neg0  <= q_data.neg;

      xs[0] <= GAIN_Q60;
      ys[0] <= '0;
      zs[0] <= neg0 ? -ang : ang;
      qs[0] <= quad0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic [63:0] ATAN = atan_pow2(i);
    always_ff @(posedge clk) begin
      if (adv) begin
        // rotate toward zero residual angle
        if (!zs[i][63]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN;
        end
        qs[i+1] <= qs[i];
      end
    end
  end

  assign c = to_q30(xs[N]);
  assign s = to_q30(ys[N]);

  always_comb begin
    case (qs[N])
      2'd0:    begin re = c;  im = s;  end
      2'd1:    begin re = -s; im = c;  end
      2'd2:    begin re = -c; im = -s; end
      default: begin re = s;  im = -c; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_data.phasor_real <= re;
      rsp_data.phasor_imag <= -im;
    end
  end
endmodule

>>> rtl/fringe_rotation_phasor_top.sv
// Fringe rotation phasor block: top level.
//
// Request channel (req_valid, req_stall, req_data) takes one item a cycle while req_stall is low:
// time offset, channel frequency, delay rate and multiband delay. A
// transaction completes at a clock edge with valid high and stall low.
// Response channel (rsp_valid, rsp_stall, rsp_data) returns one phasor
// exp(-2*pi*i*phase) in Q2.30 for each request, in order.
// The path runs through 4 front stages, a queue write and CORDIC_STAGES + 3
// back stages, the first loaded at the accepting edge. Throughput is one item
// per cycle when nothing stalls, set by the fully pipelined phase adder tree
// and the unrolled CORDIC.
// When the receiver stalls, the back pipeline holds, the 4-entry queue fills,
// and then req_stall rises and the front pipeline holds.
// Reset (rst, synchronous) empties both pipelines and the queue and loads the
// register defaults. Write registers over the APB-style port at 8*index
// only while the block is idle.
module fringe_rotation_phasor_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  frp_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output frp_pkg::rsp_t rsp_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import frp_pkg::*;

  cfg_t  cfg;
  qent_t push_data;
  qent_t pop_data;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  assign pready = 1'b1;

  frp_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  frp_front u_front (
    .clk, .rst, .cfg, .req_valid, .req_stall, .req_data,
    .q_full(full), .q_push(push), .q_data(push_data)
  );

  frp_queue u_queue (
    .clk, .rst, .push, .wdata(push_data), .pop, .rdata(pop_data), .full, .empty
  );

  frp_back u_back (
    .clk, .rst, .q_empty(empty), .q_pop(pop), .q_data(pop_data),
    .rsp_valid, .rsp_stall, .rsp_data
  );
endmodule

>>> rtl/frp_checker.sv
// Port-level checker for the fringe rotation phasor, bound to the top level.
`include "assert_macros.svh"

module frp_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input frp_pkg::rsp_t rsp_data,
  input logic          psel,
  input logic          pready
);
  import frp_pkg::*;

  logic real_ok;

  assign real_ok = (rsp_data.phasor_real <= Q30_ONE) && (rsp_data.phasor_real >= -Q30_ONE);

  `FRP_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid)
  `FRP_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && rsp_stall, $stable(rsp_data))
  `FRP_ASSERT_IMPL(a_pready, clk, rst, psel, pready)
  `FRP_ASSERT_IMPL(a_reset_empty, clk, rst, $past(rst), !rsp_valid)
  `FRP_ASSERT_IMPL(a_real_range, clk, rst, rsp_valid, real_ok)
endmodule

bind fringe_rotation_phasor_top frp_checker u_frp_checker (.*);

>>> dv/tb.sv
// Self-checking testbench for the fringe rotation phasor block.
`timescale 1ns / 1ps

module tb;
  import frp_pkg::*;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req_data;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [5:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  fringe_rotation_phasor_top u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;

  cfg_t        cur_cfg;
  rsp_t        phasor_queue[$];
  logic [63:0] atan_lut[CORDIC_STAGES];
  int          errors;
  int          stall_left;
  int          idle_cycles;
  bit          no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [127:0] sx64(input logic [63:0] v);
    return {{64{v[63]}}, v};
  endfunction

  function automatic logic [63:0] arctan_q60(input int i);
    logic [63:0] sum;
    int sh;
    sum = '0;
    if (i == 0) return PI_QUARTER_Q60;
    for (int k = 0; k < 64; k++) begin
      sh = i * (2 * k + 1);
      if (sh > 60) break;
      if (k % 2 == 1) sum = sum - (Q60_ONE >> sh) / 64'(2 * k + 1);
      else sum = sum + (Q60_ONE >> sh) / 64'(2 * k + 1);
    end
    return sum;
  endfunction

  function automatic logic [31:0] round_q30(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd536870912) >>> 30;
    if (r > 64'sd1073741824) r = 64'sd1073741824;
    if (r < -64'sd1073741824) r = -64'sd1073741824;
    return r[31:0];
  endfunction

  function automatic rsp_t phasor_of(input req_t r);
    logic [127:0] acc, term, rate_w, mbd_w, dly_w, sb_w;
    logic [63:0]  ft, sb64;
    logic [31:0]  p, res, mag, c, s, re, im;
    logic [33:0]  qsum;
    logic [1:0]   q;
    logic [95:0]  prod;
    logic signed [63:0] x, y, z, dx, dy;
    rsp_t o;
    rate_w = {{80{r.dly_rate[47]}}, r.dly_rate};
    mbd_w  = {{80{r.multiband_delay[47]}}, r.multiband_delay};
    dly_w  = cur_cfg.closure_optimise ? mbd_w
           : {{80{cur_cfg.sbd_peak_delay[47]}}, cur_cfg.sbd_peak_delay};
    sb_w   = {{126{cur_cfg.sideband_sign[1]}}, cur_cfg.sideband_sign};
    sb64   = sb_w[63:0];
    ft     = {32'b0, r.channel_freq} * {{32{r.time_offset[31]}}, r.time_offset};
    acc    = sx64(ft) * rate_w;
    term   = sx64({32'b0, r.channel_freq} - {32'b0, cur_cfg.reference_freq}) * mbd_w;
    acc    = acc + (term << 44);
    term   = dly_w * {96'b0, cur_cfg.sbd_spacing_recip} * sb_w;
    acc    = acc + (term << 38);
    term   = sx64(({50'b0, cur_cfg.sbd_bin_count} - {50'b0, cur_cfg.sbd_peak_bin}) * sb64);
    acc    = acc + (term << 86);
    p      = acc[88:57];
    // split off the nearest quadrant
    qsum   = {2'b0, p} + 34'd536870912;
    q      = qsum[31:30];
    res    = p - {q, 30'b0};
    mag    = res[31] ? -res : res;
    prod   = {64'b0, mag} * {32'b0, TWO_PI_Q60};
    z      = res[31] ? -prod[95:32] : prod[95:32];
    x      = GAIN_Q60;
    y      = '0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_lut[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_lut[i];
      end
    end
    c = round_q30(x);
    s = round_q30(y);
    case (q)
      2'd0: begin re = c;  im = s;  end
      2'd1: begin re = -s; im = c;  end
      2'd2: begin re = -c; im = -s; end
      default: begin re = s; im = -c; end
    endcase
    o.phasor_real = re;
    o.phasor_imag = -im;
    return o;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int draw_wait();
    if (no_gaps) return 0;
    return $urandom_range(0, 10);
  endfunction

  // Response side: stall per transaction, compare against oldest phasor.
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (phasor_queue.size() == 0) begin
        report("unexpected phasor real", rsp_data.phasor_real, '0);
      end else begin
        want = phasor_queue.pop_front();
        if (rsp_data.phasor_real !== want.phasor_real)
          report("phasor_real", rsp_data.phasor_real, want.phasor_real);
        if (rsp_data.phasor_imag !== want.phasor_imag)
          report("phasor_imag", rsp_data.phasor_imag, want.phasor_imag);
      end
      stall_left = draw_wait();
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SIDEBAND:   cur_cfg.sideband_sign     = val[1:0];
      REG_BIN_COUNT:  cur_cfg.sbd_bin_count     = val[13:0];
      REG_PEAK_BIN:   cur_cfg.sbd_peak_bin      = val[13:0];
      REG_PEAK_DELAY: cur_cfg.sbd_peak_delay    = val[47:0];
      REG_RECIP:      cur_cfg.sbd_spacing_recip = val[31:0];
      REG_CLOSURE:    cur_cfg.closure_optimise  = val[0];
      REG_REF_FREQ:   cur_cfg.reference_freq    = val[31:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input cfg_t c);
    write_reg(REG_SIDEBAND,   {62'b0, c.sideband_sign});
    write_reg(REG_BIN_COUNT,  {50'b0, c.sbd_bin_count});
    write_reg(REG_PEAK_BIN,   {50'b0, c.sbd_peak_bin});
    write_reg(REG_PEAK_DELAY, {16'b0, c.sbd_peak_delay});
    write_reg(REG_RECIP,      {32'b0, c.sbd_spacing_recip});
    write_reg(REG_CLOSURE,    {63'b0, c.closure_optimise});
    write_reg(REG_REF_FREQ,   {32'b0, c.reference_freq});
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (phasor_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input req_t r);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    phasor_queue.push_back(phasor_of(r));
    @(negedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic req_t rand_item();
    req_t r;
    r.time_offset     = $urandom;
    r.channel_freq    = $urandom;
    r.dly_rate        = rand48();
    r.multiband_delay = rand48();
    // occasionally use small time offsets, delay rates and multiband delays
    if ($urandom_range(0, 3) == 0) begin
      r.time_offset     = $signed($urandom_range(0, 512)) - 256;
      r.dly_rate        = 48'($signed($urandom_range(0, 4096)) - 2048);
      r.multiband_delay = 48'($signed($urandom_range(0, 4096)) - 2048);
    end
    return r;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.sideband_sign     = 2'($urandom);
    c.sbd_bin_count     = 14'($urandom_range(0, 8192));
    c.sbd_peak_bin      = 14'($urandom_range(0, 8192));
    c.sbd_peak_delay    = rand48();
    c.sbd_spacing_recip = $urandom;
    c.closure_optimise  = 1'($urandom);
    c.reference_freq    = $urandom;
    return c;
  endfunction

  req_t stim_table[] = '{
    '{32'sh0, 32'h0, 48'sh0, 48'sh0},
    '{32'sh7fff_ffff, 32'hffff_ffff, 48'sh7fff_ffff_ffff, 48'sh7fff_ffff_ffff},
    '{32'sh8000_0000, 32'hffff_ffff, 48'sh8000_0000_0000, 48'sh8000_0000_0000},
    '{32'sh8000_0000, 32'hffff_ffff, 48'sh7fff_ffff_ffff, 48'sh8000_0000_0000},
    '{32'sh7fff_ffff, 32'h0, 48'sh8000_0000_0000, 48'sh7fff_ffff_ffff},
    '{32'sh0001_0000, 32'h0000_2000, 48'sh1000_0000_0000, 48'sh0},
    '{32'shffff_0000, 32'h0000_2000, 48'sh1000_0000_0000, 48'sh0},
    '{32'sh0, 32'h0000_0001, 48'sh0, 48'sh0000_4000_0000},
    '{32'sh0, 32'h0000_0001, 48'sh0, 48'shffff_c000_0000},
    '{32'sh0, 32'h0000_0001, 48'sh0, 48'sh0000_2000_0000},
    '{32'sh0, 32'h0000_0001, 48'sh0, 48'sh0000_6000_0000},
    '{32'sh0, 32'h0000_0001, 48'sh0, 48'sh0000_1fff_ffff},
    '{32'shffff_ffff, 32'hffff_ffff, 48'shffff_ffff_ffff, 48'shffff_ffff_ffff},
    '{32'sh5555_5555, 32'haaaa_aaaa, 48'sh5555_5555_5555, 48'shaaaa_aaaa_aaaa}
  };

  initial begin
    cfg_t c;
    errors     = 0;
    stall_left = 0;
    idle_cycles = 0;
    no_gaps    = 1'b0;
    for (int i = 0; i < CORDIC_STAGES; i++) atan_lut[i] = arctan_q60(i);
    cur_cfg = '{sideband_sign: 2'b00, sbd_bin_count: '0, sbd_peak_bin: '0,
                sbd_peak_delay: '0, sbd_spacing_recip: 32'd65536,
                closure_optimise: 1'b0, reference_freq: '0};
    rst = 1'b1;
    req_valid = 1'b0;
    req_data  = '0;
    rsp_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed rows first with register defaults, then under extreme settings.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: c = cur_cfg;
        1: c = '{SB_MINUS, 14'd8192, 14'd0, 48'sh7fff_ffff_ffff, 32'hffff_ffff,
                 1'b1, 32'hffff_ffff};
        2: c = '{SB_TWO, 14'd0, 14'd8192, 48'sh8000_0000_0000, 32'h0,
                 1'b0, 32'h0};
        3: c = '{SB_PLUS, 14'd100, 14'd4000, 48'sh0000_1234_5678, 32'h0001_0000,
                 1'b0, 32'h0000_2000};
        4: c = '{2'b00, 14'd3, 14'd1, 48'shffff_ffff_ffff, 32'h8000_0000,
                 1'b1, 32'h1234_5678};
        default: c = rand_cfg();
      endcase
      if (ph > 0) begin
        wait_drained();
        write_all(c);
      end
      if (ph < 3) begin
        foreach (stim_table[i]) send_item(stim_table[i]);
      end
      for (int n = 0; n < 80; n++) begin
        if (n % 30 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        // hold off the sender until the pipeline has fully drained
        if (n == 45 && ph == 5) begin
          req_valid <= 1'b0;
          while (phasor_queue.size() != 0) @(negedge clk);
        end
        send_item(rand_item());
      end
    end

    req_valid <= 1'b0;
    while (phasor_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && phasor_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/frp_pkg.sv
rtl/frp_regs.sv
rtl/frp_front.sv
rtl/frp_queue.sv
rtl/frp_back.sv
rtl/fringe_rotation_phasor_top.sv
rtl/frp_checker.sv
dv/tb.sv
